>>> rtl/core/bse_pkg.sv
`timescale 1ns / 1ps
package bse_pkg;

	localparam int COORD_W   = 10;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 16;
	localparam int COLOR_W   = 8;
	localparam int FRAC_BITS = 26;
	// floored product of two DATA_W values always fits in SQ_W bits
	localparam int SQ_W      = 2 * DATA_W - FRAC_BITS;
	localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100);

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_RR,
		MUL_II,
		MUL_RI
	} mul_op_t;

	typedef struct packed {
		logic    load;
		mul_op_t op;
		logic    count_inc;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic count_lt_max;
		logic next_lt_max;
		logic escape;
	} dp_status_t;

	function automatic logic signed [DATA_W-1:0] sat_sq(input logic signed [SQ_W-1:0] v);
		logic fits;
		fits = (v[SQ_W-1:DATA_W-1] == {(SQ_W-DATA_W+1){1'b0}})
			|| (v[SQ_W-1:DATA_W-1] == {(SQ_W-DATA_W+1){1'b1}});
		if (fits)
			return v[DATA_W-1:0];
		else if (v[SQ_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W:0] v);
		if (v[DATA_W] == v[DATA_W-1])
			return v[DATA_W-1:0];
		else if (v[DATA_W])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage

>>> rtl/core/bse_if.sv
`timescale 1ns / 1ps
interface bse_in_if;
	import bse_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [COORD_W-1:0]       pixel_x;
	logic [COORD_W-1:0]       pixel_y;
	logic signed [DATA_W-1:0] c_real;
	logic signed [DATA_W-1:0] c_imag;
	logic signed [DATA_W-1:0] z_real_start;
	logic signed [DATA_W-1:0] z_imag_start;
	logic [CNT_W-1:0]         start_count;

	modport source(output valid, pixel_x, pixel_y, c_real, c_imag, z_real_start,
		z_imag_start, start_count, input ready);
	modport sink(input valid, pixel_x, pixel_y, c_real, c_imag, z_real_start,
		z_imag_start, start_count, output ready);
endinterface

interface bse_out_if;
	import bse_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [COORD_W-1:0]       out_x;
	logic [COORD_W-1:0]       out_y;
	logic [CNT_W-1:0]         escape_count;
	logic signed [DATA_W-1:0] final_real;
	logic signed [DATA_W-1:0] final_imag;
	logic [COLOR_W-1:0]       red;
	logic [COLOR_W-1:0]       green;
	logic [COLOR_W-1:0]       blue;

	modport source(output valid, out_x, out_y, escape_count, final_real, final_imag,
		red, green, blue, input ready);
	modport sink(input valid, out_x, out_y, escape_count, final_real, final_imag,
		red, green, blue, output ready);
endinterface

interface bse_cfg_if;
	import bse_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> rtl/core/bse_datapath.sv
`timescale 1ns / 1ps
module bse_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bse_pkg::COORD_W-1:0]      pixel_x,
	input  logic [bse_pkg::COORD_W-1:0]      pixel_y,
	input  logic signed [bse_pkg::DATA_W-1:0] c_real,
	input  logic signed [bse_pkg::DATA_W-1:0] c_imag,
	input  logic signed [bse_pkg::DATA_W-1:0] z_real_start,
	input  logic signed [bse_pkg::DATA_W-1:0] z_imag_start,
	input  logic [bse_pkg::CNT_W-1:0]        start_count,
	input  logic                             cfg_we,
	input  logic [bse_pkg::CNT_W-1:0]        cfg_data,
	input  bse_pkg::dp_cmd_t                 cmd,
	output bse_pkg::dp_status_t              status,
	output logic [bse_pkg::COORD_W-1:0]      out_x,
	output logic [bse_pkg::COORD_W-1:0]      out_y,
	output logic [bse_pkg::CNT_W-1:0]        escape_count,
	output logic signed [bse_pkg::DATA_W-1:0] final_real,
	output logic signed [bse_pkg::DATA_W-1:0] final_imag,
	output logic [bse_pkg::COLOR_W-1:0]      red,
	output logic [bse_pkg::COLOR_W-1:0]      green,
	output logic [bse_pkg::COLOR_W-1:0]      blue
);
	import bse_pkg::*;

	logic [CNT_W-1:0]         max_q;
	logic [CNT_W-1:0]         count_q;
	logic [COORD_W-1:0]       px_q;
	logic [COORD_W-1:0]       py_q;
	logic signed [DATA_W-1:0] cr_q;
	logic signed [DATA_W-1:0] ci_q;
	logic signed [DATA_W-1:0] zr_q;
	logic signed [DATA_W-1:0] zi_q;
	logic signed [SQ_W-1:0]   sqr_q;
	logic signed [SQ_W-1:0]   sqi_q;
	logic signed [2*DATA_W-1:0] p_q;
	mul_op_t                  tag_q;

	logic signed [DATA_W-1:0]   mul_a;
	logic signed [DATA_W-1:0]   mul_b;
	logic signed [2*DATA_W-1:0] prod;
	logic signed [2*DATA_W-1:0] p_floor;
	logic signed [SQ_W-1:0]     fq;
	logic signed [DATA_W-1:0]   rr_s;
	logic signed [DATA_W-1:0]   ii_s;
	logic signed [DATA_W-1:0]   ri_s;
	logic signed [DATA_W-1:0]   d_s;
	logic signed [DATA_W-1:0]   nr;
	logic signed [DATA_W-1:0]   ni;
	logic signed [DATA_W-1:0]   twice;
	logic [DATA_W:0]            ar;
	logic [SQ_W:0]              mag;
	logic [CNT_W:0]             count_nx;
	logic [COLOR_W-1:0]         green_nx;

	assign mul_a = (cmd.op == MUL_II) ? zi_q : zr_q;
	assign mul_b = (cmd.op == MUL_RR) ? zr_q : zi_q;
	assign prod  = mul_a * mul_b;

	always_comb begin
		// arithmetic shift floors toward minus infinity
		p_floor = p_q >>> FRAC_BITS;
		fq      = p_floor[SQ_W-1:0];
		rr_s    = sat_sq(sqr_q);
		ii_s    = sat_sq(sqi_q);
		ri_s    = sat_sq(fq);
		d_s     = sat_add({rr_s[DATA_W-1], rr_s} - {ii_s[DATA_W-1], ii_s});
		nr      = sat_add({d_s[DATA_W-1], d_s} + {cr_q[DATA_W-1], cr_q});
		ar      = ri_s[DATA_W-1] ? -{ri_s[DATA_W-1], ri_s} : {ri_s[DATA_W-1], ri_s};
		if (ar[DATA_W:DATA_W-2] != 3'b000)
			twice = {1'b0, {(DATA_W-1){1'b1}}};
		else
			twice = {ar[DATA_W-2:0], 1'b0};
		ni      = sat_add({twice[DATA_W-1], twice} + {ci_q[DATA_W-1], ci_q});
		// both squares are non-negative
		mag     = {2'b00, sqr_q[SQ_W-2:0]} + {2'b00, fq[SQ_W-2:0]};
		count_nx = {1'b0, count_q} + (CNT_W+1)'(1);
		green_nx = {count_q[COLOR_W-2:0], 1'b0};
	end

	assign status.count_lt_max = count_q < max_q;
	assign status.next_lt_max  = count_nx < {1'b0, max_q};
	assign status.escape       = (tag_q == MUL_II) && (mag > ((SQ_W+1)'(4) << FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_ITER_RESET;
			tag_q <= MUL_NONE;
		end else begin
			if (cfg_we)
				max_q <= cfg_data;
			tag_q <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= prod;
		if (cmd.load) begin
			px_q    <= pixel_x;
			py_q    <= pixel_y;
			cr_q    <= c_real;
			ci_q    <= c_imag;
			zr_q    <= z_real_start;
			zi_q    <= z_imag_start;
			count_q <= start_count;
		end else begin
			if (cmd.count_inc)
				count_q <= count_nx[CNT_W-1:0];
			if (tag_q == MUL_RI) begin
				zr_q <= nr;
				zi_q <= ni;
			end
		end
		if (tag_q == MUL_RR)
			sqr_q <= fq;
		if (tag_q == MUL_II)
			sqi_q <= fq;
		if (cmd.out_load) begin
			out_x        <= px_q;
			out_y        <= py_q;
			escape_count <= count_q;
			final_real   <= zr_q;
			final_imag   <= zi_q;
			red          <= count_q[COLOR_W-1:0];
			green        <= green_nx;
			blue         <= count_q[COLOR_W-1:0] + green_nx;
		end
	end

endmodule

>>> rtl/core/bse_ctrl.sv
`timescale 1ns / 1ps
module bse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bse_pkg::dp_status_t status,
	output bse_pkg::dp_cmd_t    cmd
);
	import bse_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_RR,
		S_II,
		S_RI,
		S_UPD,
		S_CHK,
		S_DONE
	} state_t;

	state_t state_q;
	logic   first_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.op        = MUL_NONE;
		cmd.count_inc = 1'b0;
		cmd.out_load  = (state_q == S_DONE) && out_free;
		case (state_q)
			S_RR: cmd.op = MUL_RR;
			S_II: cmd.op = MUL_II;
			S_RI: cmd.op = MUL_RI;
			S_CHK: begin
				if (!status.escape) begin
					cmd.count_inc = 1'b1;
					if (status.next_lt_max)
						cmd.op = MUL_RI;
				end
			end
			default: cmd.op = MUL_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_TEST;
						first_q <= 1'b1;
					end
				end
				S_TEST: state_q <= status.count_lt_max ? S_RR : S_DONE;
				S_RR: state_q <= S_II;
				// first pass only squares the start point, no escape test
				S_II: state_q <= first_q ? S_RI : S_CHK;
				S_RI: state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_RR;
					first_q <= 1'b0;
				end
				S_CHK: begin
					if (status.escape || !status.next_lt_max)
						state_q <= S_DONE;
					else
						state_q <= S_UPD;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_to_test: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_TEST)
		else $error("accepted word did not start the limit test");

	a_upd_then_square: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |=> state_q == S_RR && !first_q)
		else $error("z update not followed by squaring");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE && out_valid_q)
		else $error("result overwritten while previous word pending");

	a_no_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE || state_q == S_DONE |-> cmd.op == MUL_NONE && !cmd.count_inc)
		else $error("datapath activity outside an item");

endmodule

>>> rtl/core/burning_ship_escape_time.sv
`timescale 1ns / 1ps
// Burning Ship escape-time engine. One pixel word in, one result word out, one pixel
// in flight at a time; a finished result waits in the output register while the next
// pixel runs. A pixel whose start count is already at or above the limit goes from the
// limit test straight to the result; otherwise each map step runs on the single shared
// 32x32 multiplier, which issues the two squares and then the cross product of each
// new z in turn, and the z update must finish before the next squares can start. The
// iteration limit resets to 100.
module burning_ship_escape_time (
	input  logic  clk,
	input  logic  arst_n,
	bse_in_if.sink    pixel_in,
	bse_out_if.source pixel_out,
	bse_cfg_if.sink   cfg
);
	import bse_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_in.valid),
		.in_ready  (pixel_in.ready),
		.out_valid (pixel_out.valid),
		.out_ready (pixel_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bse_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_x      (pixel_in.pixel_x),
		.pixel_y      (pixel_in.pixel_y),
		.c_real       (pixel_in.c_real),
		.c_imag       (pixel_in.c_imag),
		.z_real_start (pixel_in.z_real_start),
		.z_imag_start (pixel_in.z_imag_start),
		.start_count  (pixel_in.start_count),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.data),
		.cmd          (cmd),
		.status       (status),
		.out_x        (pixel_out.out_x),
		.out_y        (pixel_out.out_y),
		.escape_count (pixel_out.escape_count),
		.final_real   (pixel_out.final_real),
		.final_imag   (pixel_out.final_imag),
		.red          (pixel_out.red),
		.green        (pixel_out.green),
		.blue         (pixel_out.blue)
	);

endmodule
